// ===== rtl/core/avt_pkg.sv =====
// Package for the affine vertex transform unit.
// Holds beat types, coefficient types, register indexes and saturation constants.
// Depends on nothing.
package avt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned RegW    = 64;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumRows = 3;

  localparam logic [CoordW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] SatMin = 32'h8000_0000;

  localparam logic [RegW-1:0] CoefOne  = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] CoefZero = 64'h0000_0000_0000_0000;

  typedef enum logic [RegIdxW-1:0] {
    RegM0M1   = 3'd0,
    RegM2M4   = 3'd1,
    RegM5M6   = 3'd2,
    RegM8M9   = 3'd3,
    RegM10M12 = 3'd4,
    RegM13M14 = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] in_x;
    logic [CoordW-1:0] in_y;
    logic [CoordW-1:0] in_z;
  } in_beat_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [CoordW-1:0] out_z;
    logic              saturated;
  } out_beat_t;

  // Coefficients of one output row: x, y and z weights and the translation.
  typedef struct packed {
    logic [CoordW-1:0] ma;
    logic [CoordW-1:0] mb;
    logic [CoordW-1:0] mc;
    logic [CoordW-1:0] mt;
  } row_coef_t;

  typedef struct packed {
    logic [CoordW-1:0] res;
    logic              sat;
  } row_res_t;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic sat_en;
  } pipe_ctrl_t;

endpackage

// ===== rtl/core/avt_cfg_regs.sv =====
// Coefficient register file of the affine vertex transform unit.
// Holds the six 64-bit registers and sorts the elements into rows.
// Depends on avt_pkg.
module avt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [avt_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [avt_pkg::RegW-1:0]      cfg_wdata_i,
  output avt_pkg::row_coef_t            row_coef_o [avt_pkg::NumRows]
);

  logic [avt_pkg::RegW-1:0] m0_m1_q, m2_m4_q, m5_m6_q, m8_m9_q, m10_m12_q, m13_m14_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_m1_q    <= avt_pkg::CoefOne;
      m2_m4_q    <= avt_pkg::CoefZero;
      m5_m6_q    <= avt_pkg::CoefOne;
      m8_m9_q    <= avt_pkg::CoefZero;
      m10_m12_q  <= avt_pkg::CoefOne;
      m13_m14_q  <= avt_pkg::CoefZero;
    end else if (cfg_we_i) begin
      case (avt_pkg::cfg_reg_e'(cfg_index_i))
        avt_pkg::RegM0M1:   m0_m1_q   <= cfg_wdata_i;
        avt_pkg::RegM2M4:   m2_m4_q   <= cfg_wdata_i;
        avt_pkg::RegM5M6:   m5_m6_q   <= cfg_wdata_i;
        avt_pkg::RegM8M9:   m8_m9_q   <= cfg_wdata_i;
        avt_pkg::RegM10M12: m10_m12_q <= cfg_wdata_i;
        avt_pkg::RegM13M14: m13_m14_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Column-major matrix: row r uses elements r, 4+r, 8+r and 12+r.
  assign row_coef_o[0] = '{ma: m0_m1_q[31:0],   mb: m2_m4_q[63:32],
                           mc: m8_m9_q[31:0],   mt: m10_m12_q[63:32]};
  assign row_coef_o[1] = '{ma: m0_m1_q[63:32],  mb: m5_m6_q[31:0],
                           mc: m8_m9_q[63:32],  mt: m13_m14_q[31:0]};
  assign row_coef_o[2] = '{ma: m2_m4_q[31:0],   mb: m5_m6_q[63:32],
                           mc: m10_m12_q[31:0], mt: m13_m14_q[63:32]};

endmodule

// ===== rtl/core/avt_row_pipe.sv =====
// Datapath of one output row: multiply, sum, shift and saturate in three stages.
// Stage loads are driven by the top level's valid chain.
// Depends on avt_pkg.
module avt_row_pipe #(
  parameter int unsigned FracBits = 16
) (
  input  logic                        clk_i,
  input  avt_pkg::pipe_ctrl_t         ctrl_i,
  input  logic                        point_i,
  input  logic [avt_pkg::CoordW-1:0]  x_i,
  input  logic [avt_pkg::CoordW-1:0]  y_i,
  input  logic [avt_pkg::CoordW-1:0]  z_i,
  input  avt_pkg::row_coef_t          coef_i,
  output avt_pkg::row_res_t           res_o
);

  localparam int unsigned SumW = avt_pkg::ProdW + 2;

  logic signed [avt_pkg::CoordW-1:0] xs, ys, zs, mas, mbs, mcs, mts;
  logic signed [avt_pkg::ProdW-1:0]  px_d, py_d, pz_d, pt_d;
  logic signed [avt_pkg::ProdW-1:0]  px_q, py_q, pz_q, pt_q;
  logic signed [SumW-1:0]            sum_d, sum_q, shr;
  logic                              ovf;
  avt_pkg::row_res_t                 res_d, res_q;

  assign xs  = $signed(x_i);
  assign ys  = $signed(y_i);
  assign zs  = $signed(z_i);
  assign mas = $signed(coef_i.ma);
  assign mbs = $signed(coef_i.mb);
  assign mcs = $signed(coef_i.mc);
  assign mts = $signed(coef_i.mt);

  always_comb begin
    px_d = avt_pkg::ProdW'(xs) * avt_pkg::ProdW'(mas);
    py_d = avt_pkg::ProdW'(ys) * avt_pkg::ProdW'(mbs);
    pz_d = avt_pkg::ProdW'(zs) * avt_pkg::ProdW'(mcs);
    pt_d = point_i ? (avt_pkg::ProdW'(mts) <<< FracBits) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      pt_q <= pt_d;
    end
  end

  assign sum_d = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q) + SumW'(pt_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  // The shifted sum fits in 32 bits only when all bits above bit 31 match it.
  always_comb begin
    shr = sum_q >>> FracBits;
    ovf = !((&shr[SumW-1:avt_pkg::CoordW-1]) || !(|shr[SumW-1:avt_pkg::CoordW-1]));
    res_d.sat = ovf;
    if (ovf) begin
      res_d.res = shr[SumW-1] ? avt_pkg::SatMin : avt_pkg::SatMax;
    end else begin
      res_d.res = shr[avt_pkg::CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sat_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/affine_vertex_transform_unit.sv =====
// Affine vertex transform: three-stage pipeline; an accepted input beat passes the
// multiply, sum and saturate registers in order to the output. Throughput is one
// beat per cycle while the output is not stalled; stalls on the output back up the
// pipeline without loss. Reset clears all valid bits and loads the identity matrix.
// Depends on avt_pkg, avt_cfg_regs and avt_row_pipe.
module affine_vertex_transform_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  avt_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output avt_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [avt_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [avt_pkg::RegW-1:0]      cfg_wdata_i
);

  avt_pkg::row_coef_t  row_coef [avt_pkg::NumRows];
  avt_pkg::row_res_t   row_res  [avt_pkg::NumRows];
  avt_pkg::pipe_ctrl_t ctrl;
  logic                mul_vld_q, sum_vld_q, sat_vld_q;
  logic                mul_rdy, sum_rdy, sat_rdy;

  avt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_coef_o  (row_coef)
  );

  assign sat_rdy = !sat_vld_q || out_ready_i;
  assign sum_rdy = !sum_vld_q || sat_rdy;
  assign mul_rdy = !mul_vld_q || sum_rdy;

  assign in_ready_o   = mul_rdy;
  assign ctrl.mul_en  = in_valid_i && mul_rdy;
  assign ctrl.sum_en  = mul_vld_q && sum_rdy;
  assign ctrl.sat_en  = sum_vld_q && sat_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      sat_vld_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_vld_q <= in_valid_i;
      end
      if (sum_rdy) begin
        sum_vld_q <= mul_vld_q;
      end
      if (sat_rdy) begin
        sat_vld_q <= sum_vld_q;
      end
    end
  end

  for (genvar r = 0; r < avt_pkg::NumRows; r++) begin : g_row
    avt_row_pipe #(
      .FracBits (FRAC_BITS)
    ) u_row (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .point_i (!in_data_i.action),
      .x_i     (in_data_i.in_x),
      .y_i     (in_data_i.in_y),
      .z_i     (in_data_i.in_z),
      .coef_i  (row_coef[r]),
      .res_o   (row_res[r])
    );
  end

  assign out_valid_o          = sat_vld_q;
  assign out_data_o.out_x     = row_res[0].res;
  assign out_data_o.out_y     = row_res[1].res;
  assign out_data_o.out_z     = row_res[2].res;
  assign out_data_o.saturated = row_res[0].sat || row_res[1].sat || row_res[2].sat;

endmodule

// ===== tb/sv/affine_vertex_transform_unit_test.sv =====
// Self-checking testbench for affine_vertex_transform_unit: drives vertex beats
// and coefficient writes, and checks every output beat against a Q16.16 predictor.
// Depends on avt_pkg and the affine_vertex_transform_unit RTL.
module affine_vertex_transform_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits      = 16;
  localparam int unsigned NumCoefRegs   = 6;
  localparam int unsigned AccW          = 68;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned NumRandPhases = 8;
  localparam int unsigned BeatsPerPhase = 48;

  localparam logic ActPoint     = 1'b0;
  localparam logic ActDirection = 1'b1;

  localparam logic signed [AccW-1:0] RowMax =
    {{(AccW-avt_pkg::CoordW){1'b0}}, avt_pkg::SatMax};
  localparam logic signed [AccW-1:0] RowMin =
    {{(AccW-avt_pkg::CoordW){1'b1}}, avt_pkg::SatMin};

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  avt_pkg::in_beat_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  avt_pkg::out_beat_t           out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic [avt_pkg::RegIdxW-1:0]  cfg_index_i = '0;
  logic [avt_pkg::RegW-1:0]     cfg_wdata_i = '0;

  logic [avt_pkg::RegW-1:0] coef_regs [NumCoefRegs];
  avt_pkg::in_beat_t        pending_vertices [$];
  avt_pkg::out_beat_t       predicted_vertices [$];
  int unsigned              send_idle_pct = 0;
  int unsigned              recv_idle_pct = 0;
  int unsigned              mismatch_count = 0;

  affine_vertex_transform_unit #(
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [avt_pkg::CoordW-1:0] coef_at(int unsigned slot);
    return coef_regs[slot / 2][(slot % 2) * avt_pkg::CoordW +: avt_pkg::CoordW];
  endfunction

  function automatic avt_pkg::out_beat_t transform_vertex(avt_pkg::in_beat_t beat);
    avt_pkg::out_beat_t                res;
    logic signed [avt_pkg::CoordW-1:0] coord [avt_pkg::NumRows];
    logic [avt_pkg::CoordW-1:0]        row_val [avt_pkg::NumRows];
    logic signed [AccW-1:0]            acc;
    logic signed [AccW-1:0]            lhs;
    logic signed [AccW-1:0]            rhs;
    coord[0] = beat.in_x;
    coord[1] = beat.in_y;
    coord[2] = beat.in_z;
    res = '0;
    for (int unsigned row = 0; row < avt_pkg::NumRows; row++) begin
      acc = '0;
      for (int unsigned col = 0; col < avt_pkg::NumRows; col++) begin
        lhs = coord[col];
        rhs = coef_at(col * avt_pkg::NumRows + row);
        acc += lhs * rhs;
      end
      if (beat.action == ActPoint) begin
        rhs = coef_at(avt_pkg::NumRows * avt_pkg::NumRows + row);
        acc += rhs <<< FracBits;
      end
      acc = acc >>> FracBits;
      if (acc > RowMax) begin
        row_val[row] = avt_pkg::SatMax;
        res.saturated = 1'b1;
      end else if (acc < RowMin) begin
        row_val[row] = avt_pkg::SatMin;
        res.saturated = 1'b1;
      end else begin
        row_val[row] = acc[avt_pkg::CoordW-1:0];
      end
    end
    res.out_x = row_val[0];
    res.out_y = row_val[1];
    res.out_z = row_val[2];
    return res;
  endfunction

  function automatic logic [avt_pkg::CoordW-1:0] rand_fixed(int unsigned span);
    logic [avt_pkg::CoordW-1:0] val;
    int unsigned                bound;
    case ($urandom_range(0, 7))
      0: val = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: val = avt_pkg::SatMax;
          1: val = avt_pkg::SatMin;
          2: val = avt_pkg::CoefOne[avt_pkg::CoordW-1:0];
          default: val = -avt_pkg::CoefOne[avt_pkg::CoordW-1:0];
        endcase
      end
      default: begin
        bound = 1 << $urandom_range(4, span);
        val = $urandom_range(0, 2 * bound - 1) - bound;
      end
    endcase
    return val;
  endfunction

  task automatic write_coef_reg(input logic [avt_pkg::RegIdxW-1:0] idx,
                                input logic [avt_pkg::RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx <= avt_pkg::RegM13M14) coef_regs[idx] = val;
  endtask

  task automatic load_uniform(input logic [avt_pkg::RegW-1:0] val);
    write_coef_reg(avt_pkg::RegM0M1, val);
    write_coef_reg(avt_pkg::RegM2M4, val);
    write_coef_reg(avt_pkg::RegM5M6, val);
    write_coef_reg(avt_pkg::RegM8M9, val);
    write_coef_reg(avt_pkg::RegM10M12, val);
    write_coef_reg(avt_pkg::RegM13M14, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_vertex(input logic act, input logic [avt_pkg::CoordW-1:0] x,
                              input logic [avt_pkg::CoordW-1:0] y,
                              input logic [avt_pkg::CoordW-1:0] z);
    avt_pkg::in_beat_t beat;
    beat.action = act;
    beat.in_x   = x;
    beat.in_y   = y;
    beat.in_z   = z;
    pending_vertices.push_back(beat);
  endtask

  // The state is sampled at the falling edge, once every update of the rising edge has settled.
  task automatic drain_pipeline();
    while (pending_vertices.size() != 0 || in_valid_i || predicted_vertices.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predicted_vertices.push_back(transform_vertex(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i  <= pending_vertices.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    avt_pkg::out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_vertices.size() == 0) begin
          $error("output beat with no prediction pending: %h", out_data_o);
          mismatch_count++;
        end else begin
          want = predicted_vertices.pop_front();
          if (out_data_o.out_x !== want.out_x) begin
            $error("out_x expected %h actual %h", want.out_x, out_data_o.out_x);
            mismatch_count++;
          end
          if (out_data_o.out_y !== want.out_y) begin
            $error("out_y expected %h actual %h", want.out_y, out_data_o.out_y);
            mismatch_count++;
          end
          if (out_data_o.out_z !== want.out_z) begin
            $error("out_z expected %h actual %h", want.out_z, out_data_o.out_z);
            mismatch_count++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated expected %b actual %b", want.saturated, out_data_o.saturated);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    coef_regs[avt_pkg::RegM0M1]   = avt_pkg::CoefOne;
    coef_regs[avt_pkg::RegM2M4]   = avt_pkg::CoefZero;
    coef_regs[avt_pkg::RegM5M6]   = avt_pkg::CoefOne;
    coef_regs[avt_pkg::RegM8M9]   = avt_pkg::CoefZero;
    coef_regs[avt_pkg::RegM10M12] = avt_pkg::CoefOne;
    coef_regs[avt_pkg::RegM13M14] = avt_pkg::CoefZero;
    send_idle_pct = 14;
    recv_idle_pct = 69;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The identity matrix after reset must pass every coordinate through.
    queue_vertex(ActPoint, avt_pkg::SatMax, avt_pkg::SatMax, avt_pkg::SatMax);
    queue_vertex(ActDirection, avt_pkg::SatMax, avt_pkg::SatMax, avt_pkg::SatMax);
    queue_vertex(ActPoint, avt_pkg::SatMin, avt_pkg::SatMin, avt_pkg::SatMin);
    queue_vertex(ActDirection, avt_pkg::SatMin, avt_pkg::SatMin, avt_pkg::SatMin);
    queue_vertex(ActPoint, '0, '0, '0);
    queue_vertex(ActDirection, '1, '1, '1);
    queue_vertex(ActPoint, avt_pkg::CoefOne[avt_pkg::CoordW-1:0],
                 -avt_pkg::CoefOne[avt_pkg::CoordW-1:0], 32'h0000_8000);
    queue_vertex(ActDirection, 32'h1234_5678, 32'h8765_4321, 32'h0000_0001);
    drain_pipeline();

    load_uniform({avt_pkg::SatMax, avt_pkg::SatMax});
    queue_vertex(ActPoint, avt_pkg::SatMax, avt_pkg::SatMax, avt_pkg::SatMax);
    queue_vertex(ActDirection, avt_pkg::SatMin, avt_pkg::SatMin, avt_pkg::SatMin);
    queue_vertex(ActPoint, '0, '0, '0);
    queue_vertex(ActDirection, avt_pkg::CoefOne[avt_pkg::CoordW-1:0], '0, '0);
    drain_pipeline();

    load_uniform({avt_pkg::SatMin, avt_pkg::SatMin});
    queue_vertex(ActPoint, avt_pkg::SatMin, avt_pkg::SatMin, avt_pkg::SatMin);
    queue_vertex(ActDirection, avt_pkg::SatMax, avt_pkg::SatMax, avt_pkg::SatMax);
    queue_vertex(ActPoint, '0, '0, '0);
    drain_pipeline();

    // Every coefficient is minus one LSB, so tiny sums must round toward minus infinity.
    load_uniform('1);
    queue_vertex(ActDirection, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_vertex(ActPoint, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_vertex(ActDirection, '1, '1, '1);
    queue_vertex(ActPoint, avt_pkg::SatMin, avt_pkg::SatMax, '1);
    drain_pipeline();

    load_uniform(avt_pkg::CoefZero);
    queue_vertex(ActPoint, avt_pkg::SatMax, avt_pkg::SatMin, 32'h5555_AAAA);
    queue_vertex(ActDirection, avt_pkg::SatMin, avt_pkg::SatMax, 32'hAAAA_5555);
    drain_pipeline();

    for (int unsigned phase = 0; phase < NumRandPhases; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 69;
      end else if (phase < 6) begin
        send_idle_pct = 69;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int idx = int'(avt_pkg::RegM0M1); idx <= int'(avt_pkg::RegM13M14); idx++)
        write_coef_reg(avt_pkg::RegIdxW'(idx), {rand_fixed(18), rand_fixed(18)});
      write_coef_reg(avt_pkg::RegIdxW'($urandom_range(int'(avt_pkg::RegM13M14) + 1,
                                                       (1 << avt_pkg::RegIdxW) - 1)),
                     {$urandom, $urandom});
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      repeat (BeatsPerPhase)
        queue_vertex(1'($urandom_range(0, 1)), rand_fixed(26), rand_fixed(26), rand_fixed(26));
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/avt_pkg.sv
rtl/core/avt_cfg_regs.sv
rtl/core/avt_row_pipe.sv
rtl/core/affine_vertex_transform_unit.sv
tb/sv/affine_vertex_transform_unit_test.sv
